// ===== hdl/gbdt_pkg.sv =====
// ----------------------------------------------------------------------------
// gbdt_pkg
// Shared types and codes for the graph traversal block.
// ----------------------------------------------------------------------------
package gbdt_pkg;

  localparam logic [1:0] MODE_EDGE = 2'd0;
  localparam logic [1:0] MODE_BFS  = 2'd1;
  localparam logic [1:0] MODE_DFS  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [1:0] ST_VERTEX  = 2'd0;
  localparam logic [1:0] ST_STORED  = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_CHK,
    S_EDGE_W2,
    S_SINGLE,
    S_POP,
    S_POP_WAIT,
    S_NODE,
    S_NB_RD,
    S_NB_CHK,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;       // capture input item
    logic edge_w1;    // write first edge entry
    logic edge_w2;    // write other edge entry (at v, after the first)
    logic trav_init;  // reset visited (start only if bfs), push start
    logic pop;        // read work list top/head
    logic node_take;  // latch popped node, mark if dfs, read degree
    logic nb_rd;      // read neighbor
    logic nb_push;    // push neighbor if eligible
    logic nb_adv;     // advance neighbor index
    logic out_load;   // load output register
    logic [1:0] out_status;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       in_range;
    logic       edge_full;
    logic       list_empty;
    logic       node_visited;
    logic       nb_done;
    logic       trav_done;
    logic       out_busy;
  } stat_t;

endpackage

// ===== hdl/graph_bfs_dfs_traversal.sv =====
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal
// Undirected graph store with breadth-first and depth-first traversal.
// ----------------------------------------------------------------------------
// channel | signals                                      | dir
// input   | in_valid/in_ready, mode, first_vertex, second_vertex | in
// output  | out_valid/out_ready, visited_vertex, status, last    | out
// config  | cfg_we, cfg_data (vertex_count)              | in
//
// Edge item: checked, then both entries written and stored, or rejected; no new
// item is taken until its result is loaded. Traversal: each vertex is popped and
// taken, its neighbors read and pushed in turn; visited depth-first entries are skipped.
// Reset is synchronous; degree entries carry valid flags, so no clearing pass.
// A stalled output holds the sequencer before the next vertex is sent.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [5:0] first_vertex,
  input  logic [5:0] second_vertex,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] visited_vertex,
  output logic [1:0] status,
  output logic       last,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data
);
  import gbdt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gbdt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .mode, .stat, .cmd
  );

  gbdt_datapath #(.MAX_VERTICES(MAX_VERTICES), .MAX_DEGREE(MAX_DEGREE)) u_dp (
    .clk, .rst, .mode, .first_vertex, .second_vertex, .cfg_we, .cfg_data,
    .cmd, .stat, .out_valid, .out_ready, .visited_vertex, .status, .last
  );
endmodule

// ===== hdl/gbdt_datapath.sv =====
// ----------------------------------------------------------------------------
// gbdt_datapath
// Neighbor store, degree counters, visited map, work list and output register.
// ----------------------------------------------------------------------------
module gbdt_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_DEGREE   = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      mode,
  input  logic [5:0]      first_vertex,
  input  logic [5:0]      second_vertex,
  input  logic            cfg_we,
  input  logic [6:0]      cfg_data,
  input  gbdt_pkg::cmd_t  cmd,
  output gbdt_pkg::stat_t stat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [5:0]      visited_vertex,
  output logic [1:0]      status,
  output logic            last
);
  import gbdt_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int SD = MAX_VERTICES * MAX_DEGREE;
  localparam int SW = $clog2(SD);
  localparam int WD = SD + 1;
  localparam int WW = $clog2(WD + 1);

  logic [6:0] vertex_count;
  logic [5:0] store [SD];
  logic [5:0] work [WD];
  logic [DW-1:0] degree [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] deg_valid;
  logic [MAX_VERTICES-1:0] visited;
  logic [1:0] mode_r;
  logic [5:0] u_r, v_r, node, nb_rdata, work_rdata;
  logic [WW-1:0] head, tail;
  logic [DW-1:0] idx;
  logic [6:0] emitted;
  logic [6:0] eff;

  always_ff @(posedge clk) begin
    if (rst) vertex_count <= 7'd64;
    else if (cfg_we) vertex_count <= cfg_data;
  end
  assign eff = (vertex_count > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vertex_count;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      u_r    <= first_vertex;
      v_r    <= second_vertex;
    end
  end

  // degree memory: port a reads u at load or the popped node, port b reads v
  logic deg_re_a, deg_we;
  logic [VW-1:0] deg_raddr_a, deg_waddr;
  logic [DW-1:0] deg_a_raw, deg_b_raw, deg_wdata;
  logic a_ok, b_ok;
  logic [DW-1:0] du, dv, dv_w;
  logic [DW:0] du2;

  assign deg_re_a    = cmd.load || cmd.node_take;
  assign deg_raddr_a = cmd.node_take ? work_rdata[VW-1:0] : first_vertex[VW-1:0];

  always_ff @(posedge clk) begin
    if (deg_we) degree[deg_waddr] <= deg_wdata;
    if (deg_re_a) deg_a_raw <= degree[deg_raddr_a];
    if (cmd.load) deg_b_raw <= degree[second_vertex[VW-1:0]];
  end
  always_ff @(posedge clk) begin
    if (rst) deg_valid <= '0;
    else if (deg_we) deg_valid[deg_waddr] <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (deg_re_a) a_ok <= deg_valid[deg_raddr_a];
    if (cmd.load) b_ok <= deg_valid[second_vertex[VW-1:0]];
  end

  assign du   = a_ok ? deg_a_raw : '0;
  assign dv   = b_ok ? deg_b_raw : '0;
  // self-loop: second entry lands after the first
  assign dv_w = (u_r == v_r) ? du + DW'(1) : dv;
  assign du2  = {1'b0, du} + (DW+1)'(2);

  always_comb begin
    deg_we    = cmd.edge_w1 || cmd.edge_w2;
    deg_waddr = cmd.edge_w1 ? u_r[VW-1:0] : v_r[VW-1:0];
    deg_wdata = cmd.edge_w1 ? du + DW'(1) : dv_w + DW'(1);
  end

  always_comb begin
    stat.mode     = mode_r;
    stat.in_range = ({1'b0, u_r} < eff) &&
                    (mode_r != MODE_EDGE || {1'b0, v_r} < eff);
    if (u_r == v_r) stat.edge_full = du2 > (DW+1)'(MAX_DEGREE);
    else stat.edge_full = (du >= DW'(MAX_DEGREE)) || (dv >= DW'(MAX_DEGREE));
    stat.list_empty   = (mode_r == MODE_BFS) ? (head == tail) : (tail == '0);
    stat.node_visited = visited[work_rdata[VW-1:0]];
    stat.nb_done      = (idx >= du);
    stat.trav_done    = (mode_r == MODE_BFS) && (emitted >= 7'(MAX_VERTICES));
    stat.out_busy     = out_valid && !out_ready;
  end

  logic [SW-1:0] st_waddr, st_raddr;
  logic [5:0] st_wdata;
  logic st_we;
  always_comb begin
    st_we    = cmd.edge_w1 || cmd.edge_w2;
    st_waddr = cmd.edge_w1 ? SW'(u_r[VW-1:0] * MAX_DEGREE + du)
                           : SW'(v_r[VW-1:0] * MAX_DEGREE + dv_w);
    st_wdata = cmd.edge_w1 ? v_r : u_r;
    st_raddr = SW'(node[VW-1:0] * MAX_DEGREE + idx[IW-1:0]);
  end
  always_ff @(posedge clk) begin
    if (st_we) store[st_waddr] <= st_wdata;
    nb_rdata <= store[st_raddr];
  end

  // work list
  logic push_ok;
  assign push_ok = cmd.nb_push && ({1'b0, nb_rdata} < eff) &&
                   !visited[nb_rdata[VW-1:0]] && (tail < WW'(WD));
  logic [WW-1:0] rd_addr;
  assign rd_addr = (mode_r == MODE_BFS) ? head : tail - WW'(1);
  always_ff @(posedge clk) begin
    if (cmd.trav_init) work[0] <= u_r;
    else if (push_ok) work[tail[$clog2(WD)-1:0]] <= nb_rdata;
    if (cmd.pop) work_rdata <= work[rd_addr[$clog2(WD)-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0; tail <= '0; visited <= '0; idx <= '0; emitted <= '0;
    end else begin
      if (cmd.trav_init) begin
        head <= '0; tail <= WW'(1); emitted <= '0;
        visited <= (mode_r == MODE_BFS) ? (MAX_VERTICES'(1) << u_r[VW-1:0]) : '0;
      end else begin
        if (cmd.pop) begin
          if (mode_r == MODE_BFS) head <= head + WW'(1);
          else tail <= tail - WW'(1);
        end
        if (cmd.node_take) begin
          idx <= '0;
          if (mode_r == MODE_DFS) visited[work_rdata[VW-1:0]] <= 1'b1;
        end
        if (push_ok) begin
          tail <= tail + WW'(1);
          if (mode_r == MODE_BFS) visited[nb_rdata[VW-1:0]] <= 1'b1;
        end
        if (cmd.nb_adv) idx <= idx + DW'(1);
        if (cmd.out_load && cmd.out_status == ST_VERTEX) emitted <= emitted + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.node_take) node <= work_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      visited_vertex <= (cmd.out_status == ST_VERTEX) ? node : 6'd0;
      status         <= cmd.out_status;
      last           <= cmd.out_last;
    end
  end
endmodule

// ===== hdl/gbdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbdt_ctrl
// Sequencer for edge loads and breadth/depth-first traversals.
// ----------------------------------------------------------------------------
module gbdt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      mode,
  input  gbdt_pkg::stat_t stat,
  output gbdt_pkg::cmd_t  cmd
);
  import gbdt_pkg::*;

  state_t state, state_next;
  logic [1:0] single_st, single_st_next;
  logic emit_pend, emit_pend_next;
  logic node_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; single_st <= ST_RANGE; emit_pend <= 1'b0;
    end else begin
      state <= state_next; single_st <= single_st_next; emit_pend <= emit_pend_next;
    end
  end

  assign in_ready = (state == S_IDLE) && !emit_pend;

  // popped node gives a new vertex (depth-first skips visited entries)
  assign node_new = !(stat.mode == MODE_DFS && stat.node_visited);

  // vertex held (emit_pend) until a new vertex, empty list or bfs cap
  always_comb begin
    state_next     = state;
    single_st_next = single_st;
    emit_pend_next = emit_pend;
    unique case (state)
      S_IDLE: if (in_valid && in_ready && mode != MODE_NONE) state_next = S_EDGE_CHK;
      S_EDGE_CHK: begin
        if (!stat.in_range) begin
          single_st_next = ST_RANGE; state_next = S_SINGLE;
        end else if (stat.mode == MODE_EDGE) begin
          if (stat.edge_full) begin
            single_st_next = ST_DROPPED; state_next = S_SINGLE;
          end else state_next = S_EDGE_W2;
        end else state_next = S_POP;
      end
      S_EDGE_W2: begin single_st_next = ST_STORED; state_next = S_SINGLE; end
      S_SINGLE: if (!stat.out_busy) state_next = S_IDLE;
      S_POP: begin
        if (stat.list_empty || stat.trav_done) begin
          if (!stat.out_busy) begin emit_pend_next = 1'b0; state_next = S_IDLE; end
        end else state_next = S_POP_WAIT;
      end
      S_POP_WAIT: state_next = S_NODE;
      S_NODE: begin
        if (!node_new) state_next = S_POP;
        else if (!emit_pend || !stat.out_busy) begin
          emit_pend_next = 1'b0; state_next = S_NB_RD;
        end
      end
      S_NB_RD: state_next = stat.nb_done ? S_EMIT : S_NB_CHK;
      S_NB_CHK: state_next = S_NB_RD;
      S_EMIT: begin emit_pend_next = 1'b1; state_next = S_POP; end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.load = in_valid && in_ready;
      S_EDGE_CHK: begin
        cmd.edge_w1   = stat.in_range && stat.mode == MODE_EDGE && !stat.edge_full;
        cmd.trav_init = stat.in_range && stat.mode != MODE_EDGE;
      end
      S_EDGE_W2: cmd.edge_w2 = 1'b1;
      S_SINGLE: begin
        cmd.out_load = !stat.out_busy; cmd.out_status = single_st; cmd.out_last = 1'b1;
      end
      S_POP: begin
        if (stat.list_empty || stat.trav_done) begin
          cmd.out_load = emit_pend && !stat.out_busy;
          cmd.out_last = 1'b1;
        end else begin
          cmd.pop = 1'b1;
        end
      end
      S_POP_WAIT: ;
      S_NODE: begin
        if (node_new && (!emit_pend || !stat.out_busy)) begin
          cmd.out_load  = emit_pend;
          cmd.node_take = 1'b1;
        end
      end
      S_NB_RD: cmd.nb_rd = 1'b1;
      S_NB_CHK: begin cmd.nb_push = 1'b1; cmd.nb_adv = 1'b1; end
      S_EMIT: ;
      default: ;
    endcase
    cmd.out_status = (state == S_SINGLE) ? single_st : ST_VERTEX;
  end
endmodule

// ===== hdl/gbdt_checker.sv =====
// ----------------------------------------------------------------------------
// gbdt_checker
// Port-level checks for the graph traversal block.
// ----------------------------------------------------------------------------
module gbdt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] visited_vertex,
  input logic [1:0] status
);
  import gbdt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(visited_vertex))
    else $error("output dropped while stalled");

  a_edge_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_VERTEX |-> visited_vertex == 6'd0)
    else $error("nonzero vertex on status result");

  a_out_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown({visited_vertex, status}))
    else $error("unknown output payload");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind graph_bfs_dfs_traversal gbdt_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .visited_vertex, .status
);
